>>> rtl/core/text_terminal_writer_assert.svh
// Assertion macros for the text terminal writer.
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

`ifndef SYNTH

// Check a property at every rising clock edge outside reset.
`define TTW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("text_terminal_writer assertion failed");

// Check that an expression never holds.
`define TTW_NEVER(label, expr) \
  `TTW_ASSERT(label, !(expr))

`else

`define TTW_ASSERT(label, prop)
`define TTW_NEVER(label, expr)

`endif

`endif

>>> rtl/core/ttw_pkg.sv
// Package with constants, types and the cell address function of the terminal writer.
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ATTR_W  = 8;
  localparam int WORD_W  = 16;
  localparam int CELL_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST      = 8'h7E;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_x;
    logic [ROW_W-1:0]  cursor_y;
    logic [WORD_W-1:0] cell_word;
    logic              scrolled;
  } result_t;

  // Memory address of an on-screen cell; rows rotate by the scroll offset.
  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] top);
    logic [ROW_W:0] prow;
    prow = {1'b0, r} + {1'b0, top};
    if (32'(prow) >= SCREEN_ROWS) begin
      prow = prow - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return CELL_W'(CELL_W'(prow) * CELL_W'(SCREEN_COLS)) + CELL_W'(c);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ttw_ifs.sv
// Stream interfaces for commands, results and the color register write.
`timescale 1ns / 1ps
`default_nettype none

interface ttw_cmd_if;
  import ttw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  modport source (output valid, op, char_code, col, row, input ready);
  modport sink   (input valid, op, char_code, col, row, output ready);
endinterface

interface ttw_rsp_if;
  import ttw_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  cursor_y;
  logic [WORD_W-1:0] cell_word;
  logic              scrolled;
  modport source (output valid, cursor_x, cursor_y, cell_word, scrolled, input ready);
  modport sink   (input valid, cursor_x, cursor_y, cell_word, scrolled, output ready);
endinterface

interface ttw_cfg_if;
  import ttw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_color;
  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

`default_nettype wire

>>> rtl/core/text_terminal_writer.sv
// Text terminal writer: screen memory, cursor, scroll and clear sequencing.
//
// Usage: commands enter on cmd (put character, set cursor, clear screen,
// read cell); every command gives exactly one result on rsp with the cursor
// after the command, the cell read (zero for other commands) and a scroll
// flag. cfg writes the text color; it is always ready. It must be written
// only while no command is in flight; the block itself does not enforce this.
// Timing: the result of a put character without scroll or of a set cursor
// is registered in the next cycle. A read passes through S_READ, as the
// screen memory has a registered read port. A scroll passes through
// S_SCROLL: the rotating row offset advances and the new bottom row is
// zero-filled one cell a cycle through the memory write port. A clear
// passes through S_CLEAR and fills the screen one cell a cycle.
// Reset: a clearing pass over every cell fills the screen with spaces in
// color 0x07; cmd is not ready and no result is produced for it.
// Stall: a result register and one skid slot hold results while rsp is
// stalled; one further command is taken while a result waits, then cmd
// holds ready low until the skid slot drains.
`timescale 1ns / 1ps
`default_nettype none
`include "text_terminal_writer_assert.svh"

module text_terminal_writer (
  input  wire logic clk,
  input  wire logic rst,
  ttw_cmd_if.sink   cmd,
  ttw_rsp_if.source rsp,
  ttw_cfg_if.sink   cfg
);
  import ttw_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL
  } state_t;

  state_t            state;
  logic [ATTR_W-1:0] text_color;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  top;
  logic [CELL_W-1:0] sweep_addr;
  logic [CELL_W-1:0] sweep_end;
  logic              clr_reply;
  logic              rd_ok;

  logic [WORD_W-1:0] screen_mem [CELL_COUNT];
  logic [WORD_W-1:0] mem_rdata;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_raddr;

  logic    out_valid;
  result_t out_q;
  logic    skid_valid;
  result_t skid_q;

  logic             cmd_acc;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             scr;
  logic             push;
  result_t          push_res;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [COL_W-1:0] col_bs;
  logic [ROW_W:0]   top_inc;
  logic             sweep_last;

  assign cmd.ready     = (state == S_IDLE) && !skid_valid;
  assign cmd_acc       = cmd.valid && cmd.ready;
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.cursor_x  = out_q.cursor_x;
  assign rsp.cursor_y  = out_q.cursor_y;
  assign rsp.cell_word = out_q.cell_word;
  assign rsp.scrolled  = out_q.scrolled;

  assign col_inc    = {1'b0, cur_col} + 1'b1;
  assign row_inc    = {1'b0, cur_row} + 1'b1;
  assign col_bs     = (cur_col != '0) ? cur_col - 1'b1 : cur_col;
  assign top_inc    = {1'b0, top} + 1'b1;
  assign sweep_last = (sweep_addr == sweep_end);
  assign mem_raddr  = cell_addr(cmd.row, cmd.col, top);

  always_comb begin
    col_next  = cur_col;
    row_next  = cur_row;
    scr       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    push      = 1'b0;
    push_res  = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color, CH_SPACE};
        push      = sweep_last && clr_reply;
      end
      S_SCROLL: begin
        mem_we   = 1'b1;
        push     = sweep_last;
        push_res = '{cursor_x: cur_col, cursor_y: cur_row, cell_word: '0, scrolled: 1'b1};
      end
      S_READ: begin
        push     = 1'b1;
        push_res = '{cursor_x: cur_col, cursor_y: cur_row,
                     cell_word: rd_ok ? mem_rdata : '0, scrolled: 1'b0};
      end
      S_IDLE: begin
        if (cmd_acc && op_t'(cmd.op) == OP_PUT) begin
          mem_wdata = {text_color, cmd.char_code};
          priority if (cmd.char_code == CH_NEWLINE) begin
            col_next = '0;
            if (32'(row_inc) >= SCREEN_ROWS) begin
              row_next = ROW_W'(SCREEN_ROWS - 1);
              scr      = 1'b1;
            end else begin
              row_next = row_inc[ROW_W-1:0];
            end
          end else if (cmd.char_code == CH_RETURN) begin
            col_next = '0;
          end else if (cmd.char_code == CH_BACKSPACE) begin
            col_next  = col_bs;
            mem_wdata = {text_color, CH_SPACE};
            mem_waddr = cell_addr(cur_row, col_bs, top);
            mem_we    = (32'(col_bs) < SCREEN_COLS) && (32'(cur_row) < SCREEN_ROWS);
          end else if (cmd.char_code >= CH_SPACE && cmd.char_code <= CH_LAST) begin
            mem_waddr = cell_addr(cur_row, cur_col, top);
            mem_we    = (32'(cur_col) < SCREEN_COLS) && (32'(cur_row) < SCREEN_ROWS);
            if (32'(col_inc) >= SCREEN_COLS) begin
              col_next = '0;
              if (32'(row_inc) >= SCREEN_ROWS) begin
                row_next = ROW_W'(SCREEN_ROWS - 1);
                scr      = 1'b1;
              end else begin
                row_next = row_inc[ROW_W-1:0];
              end
            end else begin
              col_next = col_inc[COL_W-1:0];
            end
          end
          push = !scr;
        end else if (cmd_acc && op_t'(cmd.op) == OP_SET) begin
          col_next = cmd.col;
          row_next = cmd.row;
          push     = 1'b1;
        end
        push_res = '{cursor_x: col_next, cursor_y: row_next, cell_word: '0, scrolled: 1'b0};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= screen_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      text_color <= RESET_COLOR;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      sweep_addr <= '0;
      sweep_end  <= CELL_W'(CELL_COUNT - 1);
      clr_reply  <= 1'b0;
      rd_ok      <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        text_color <= cfg.text_color;
      end

      // Drain the skid slot into the output register on a transfer; a new
      // result never arrives while the skid slot is full.
      if (rsp.valid && rsp.ready && skid_valid) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end else if (push && (!out_valid || rsp.ready)) begin
        out_q     <= push_res;
        out_valid <= 1'b1;
      end else if (push) begin
        skid_q     <= push_res;
        skid_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_last) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SCROLL: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_last) begin
            top   <= (32'(top_inc) >= SCREEN_ROWS) ? '0 : top_inc[ROW_W-1:0];
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_acc) begin
            unique case (op_t'(cmd.op))
              OP_PUT, OP_SET: begin
                cur_col <= col_next;
                cur_row <= row_next;
                if (scr) begin
                  // Zero-fill the physical row that becomes the new bottom row.
                  sweep_addr <= cell_addr('0, '0, top);
                  sweep_end  <= cell_addr('0, COL_W'(SCREEN_COLS - 1), top);
                  state      <= S_SCROLL;
                end
              end
              OP_CLEAR: begin
                cur_col    <= '0;
                cur_row    <= '0;
                top        <= '0;
                sweep_addr <= '0;
                sweep_end  <= CELL_W'(CELL_COUNT - 1);
                clr_reply  <= 1'b1;
                state      <= S_CLEAR;
              end
              OP_READ: begin
                rd_ok <= (32'(cmd.col) < SCREEN_COLS) && (32'(cmd.row) < SCREEN_ROWS);
                state <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TTW_ASSERT(a_top_range, (32'(top) < SCREEN_ROWS))
  `TTW_ASSERT(a_read_follows_accept, (state == S_READ) |-> $past(cmd_acc))
  `TTW_ASSERT(a_skid_behind_out, skid_valid |-> out_valid)
  `TTW_NEVER(a_sweep_overrun, ((state == S_CLEAR || state == S_SCROLL) &&
                               (32'(sweep_addr) >= CELL_COUNT)))

endmodule

`default_nettype wire

>>> tb/sv/text_terminal_writer_test.sv
// Self-checking testbench for the text terminal writer: directed table, random traffic, color phases.
`timescale 1ns / 1ps

module text_terminal_writer_test;
  import ttw_pkg::*;

  localparam int ITEMS_PER_PHASE = 119;
  localparam int PHASE_COUNT     = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 100;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int DIRECTED_COUNT  = 26;

  typedef struct {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    bit                typed;
    result_t           want;
  } dir_row_t;

  // Typed rows carry {cursor_x, cursor_y, cell_word, scrolled}; the rest use the shadow model.
  dir_row_t directed_rows [DIRECTED_COUNT] = '{
    '{OP_READ,  8'h00,        7'd0,   5'd0,  1'b1, {7'd0,   5'd0,  16'h0720, 1'b0}},
    '{OP_READ,  8'h00,        7'd79,  5'd24, 1'b1, {7'd0,   5'd0,  16'h0720, 1'b0}},
    '{OP_READ,  8'hFF,        7'd127, 5'd31, 1'b1, {7'd0,   5'd0,  16'h0000, 1'b0}},
    '{OP_PUT,   8'h41,        7'd127, 5'd31, 1'b1, {7'd1,   5'd0,  16'h0000, 1'b0}},
    '{OP_PUT,   CH_LAST,      7'd0,   5'd0,  1'b1, {7'd2,   5'd0,  16'h0000, 1'b0}},
    '{OP_PUT,   CH_SPACE,     7'd0,   5'd0,  1'b1, {7'd3,   5'd0,  16'h0000, 1'b0}},
    '{OP_PUT,   8'h1F,        7'd0,   5'd0,  1'b0, '0},
    '{OP_PUT,   8'h7F,        7'd0,   5'd0,  1'b0, '0},
    '{OP_PUT,   8'hFF,        7'd0,   5'd0,  1'b0, '0},
    '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  1'b0, '0},
    '{OP_READ,  8'h00,        7'd1,   5'd0,  1'b1, {7'd2,   5'd0,  16'h077E, 1'b0}},
    '{OP_PUT,   CH_RETURN,    7'd0,   5'd0,  1'b1, {7'd0,   5'd0,  16'h0000, 1'b0}},
    '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  1'b0, '0},
    '{OP_SET,   8'h00,        7'd79,  5'd24, 1'b1, {7'd79,  5'd24, 16'h0000, 1'b0}},
    '{OP_PUT,   8'h5A,        7'd0,   5'd0,  1'b1, {7'd0,   5'd24, 16'h0000, 1'b1}},
    '{OP_READ,  8'h00,        7'd79,  5'd23, 1'b1, {7'd0,   5'd24, 16'h075A, 1'b0}},
    '{OP_READ,  8'h00,        7'd5,   5'd24, 1'b1, {7'd0,   5'd24, 16'h0000, 1'b0}},
    '{OP_PUT,   CH_NEWLINE,   7'd0,   5'd0,  1'b1, {7'd0,   5'd24, 16'h0000, 1'b1}},
    '{OP_SET,   8'h00,        7'd127, 5'd31, 1'b1, {7'd127, 5'd31, 16'h0000, 1'b0}},
    '{OP_PUT,   8'h51,        7'd0,   5'd0,  1'b1, {7'd0,   5'd24, 16'h0000, 1'b1}},
    '{OP_SET,   8'h00,        7'd100, 5'd3,  1'b0, '0},
    '{OP_PUT,   CH_BACKSPACE, 7'd0,   5'd0,  1'b0, '0},
    '{OP_SET,   8'h00,        7'd0,   5'd30, 1'b0, '0},
    '{OP_PUT,   CH_NEWLINE,   7'd0,   5'd0,  1'b0, '0},
    '{OP_CLEAR, 8'hA5,        7'd85,  5'd17, 1'b1, {7'd0,   5'd0,  16'h0000, 1'b0}},
    '{OP_READ,  8'h00,        7'd40,  5'd12, 1'b1, {7'd0,   5'd0,  16'h0720, 1'b0}}
  };

  logic clk;
  logic rst;

  ttw_cmd_if cmd_ch ();
  ttw_rsp_if rsp_ch ();
  ttw_cfg_if cfg_ch ();

  text_terminal_writer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the screen, cursor and color register.
  logic [WORD_W-1:0] shadow_screen [CELL_COUNT];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  logic [ATTR_W-1:0] shadow_color;

  result_t awaited_results [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  error_count;
  int  results_seen;
  int  commands_sent;
  int  scroll_count;
  int  clear_count;
  int  color_writes;
  int  cycle_count;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit advance_row();
    logic [ROW_W:0] nxt;
    nxt = {1'b0, shadow_row} + 1'b1;
    if (nxt >= SCREEN_ROWS) begin
      for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) begin
        shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
      end
      for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) begin
        shadow_screen[i] = '0;
      end
      shadow_row = ROW_W'(SCREEN_ROWS - 1);
      return 1'b1;
    end
    shadow_row = nxt[ROW_W-1:0];
    return 1'b0;
  endfunction

  // Off-screen cursor positions drop the write.
  function automatic void store_cell(input logic [CHAR_W-1:0] ch);
    if (shadow_col < SCREEN_COLS && shadow_row < SCREEN_ROWS) begin
      shadow_screen[int'(shadow_row) * SCREEN_COLS + int'(shadow_col)] = {shadow_color, ch};
    end
  endfunction

  function automatic result_t emulate_command(input op_t op, input logic [CHAR_W-1:0] ch,
                                              input logic [COL_W-1:0] col,
                                              input logic [ROW_W-1:0] row);
    result_t        r;
    logic [COL_W:0] adv;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          r.scrolled = advance_row();
          shadow_col = '0;
        end else if (ch == CH_RETURN) begin
          shadow_col = '0;
        end else if (ch == CH_BACKSPACE) begin
          if (shadow_col != '0) shadow_col = shadow_col - 1'b1;
          store_cell(CH_SPACE);
        end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
          store_cell(ch);
          adv = {1'b0, shadow_col} + 1'b1;
          if (adv >= SCREEN_COLS) begin
            shadow_col = '0;
            r.scrolled = advance_row();
          end else begin
            shadow_col = adv[COL_W-1:0];
          end
        end
      end
      OP_SET: begin
        shadow_col = col;
        shadow_row = row;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = {shadow_color, CH_SPACE};
        shadow_col = '0;
        shadow_row = '0;
      end
      default: begin
        if (col < SCREEN_COLS && row < SCREEN_ROWS) begin
          r.cell_word = shadow_screen[int'(row) * SCREEN_COLS + int'(col)];
        end
      end
    endcase
    r.cursor_x = shadow_col;
    r.cursor_y = shadow_row;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (error_count < 20) $display("MISMATCH at result %0d: %s", results_seen, what);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue_command(input op_t op, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                               input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= op;
    cmd_ch.char_code <= ch;
    cmd_ch.col       <= col;
    cmd_ch.row       <= row;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = emulate_command(op, ch, col, row);
    awaited_results.push_back(typed ? want : predicted);
    if (predicted.scrolled) scroll_count++;
    if (op == OP_CLEAR) clear_count++;
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic pick_random_command(output op_t op, output logic [CHAR_W-1:0] ch,
                                     output logic [COL_W-1:0] col,
                                     output logic [ROW_W-1:0] row);
    int k;
    int spot;
    k    = $urandom_range(99);
    spot = $urandom_range(9);
    ch   = CHAR_W'($urandom_range(255));
    col  = COL_W'($urandom_range(127));
    row  = ROW_W'($urandom_range(31));
    if (k < 72) begin
      op = OP_PUT;
      if (k < 55)      ch = CHAR_W'($urandom_range(32, 126));
      else if (k < 62) ch = CH_NEWLINE;
      else if (k < 65) ch = CH_RETURN;
      else if (k < 69) ch = CH_BACKSPACE;
    end else if (k < 79) begin
      op = OP_SET;
      // Favor the bottom rows so text runs into the scroll path.
      if (k < 77) begin
        col = COL_W'($urandom_range(SCREEN_COLS - 1));
        row = (spot < 5) ? ROW_W'($urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1))
                         : ROW_W'($urandom_range(SCREEN_ROWS - 1));
      end
    end else if (k < 99) begin
      op = OP_READ;
      if (spot < 9) col = COL_W'($urandom_range(SCREEN_COLS - 1));
      if (spot < 5 && shadow_row < SCREEN_ROWS) row = shadow_row;
      else if (spot < 9) row = ROW_W'($urandom_range(SCREEN_ROWS - 1));
    end else begin
      op = OP_CLEAR;
    end
  endtask

  task automatic write_color(input logic [ATTR_W-1:0] color);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.text_color <= color;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_color = color;
    color_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: ready decided at the falling edge, with one long hold on request.
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result arrived with nothing outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.cursor_x !== want.cursor_x)
          flag_mismatch($sformatf("cursor_x %0d, expected %0d", rsp_ch.cursor_x, want.cursor_x));
        if (rsp_ch.cursor_y !== want.cursor_y)
          flag_mismatch($sformatf("cursor_y %0d, expected %0d", rsp_ch.cursor_y, want.cursor_y));
        if (rsp_ch.cell_word !== want.cell_word)
          flag_mismatch($sformatf("cell_word %h, expected %h", rsp_ch.cell_word, want.cell_word));
        if (rsp_ch.scrolled !== want.scrolled)
          flag_mismatch($sformatf("scrolled %b, expected %b", rsp_ch.scrolled, want.scrolled));
      end
      results_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped: no completion after %0d cycles", cycle_count);
    $display("text_terminal_writer_test failed");
    $finish;
  end

  initial begin
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = OP_PUT;
    cmd_ch.char_code  = '0;
    cmd_ch.col        = '0;
    cmd_ch.row        = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.text_color = '0;
    hold_req          = 1'b0;
    error_count       = 0;
    results_seen      = 0;
    commands_sent     = 0;
    scroll_count      = 0;
    clear_count       = 0;
    color_writes      = 0;
    send_idle_pct     = 31;
    recv_idle_pct     = 65;

    // Screen after reset: spaces in the reset color, cursor home.
    shadow_color = RESET_COLOR;
    void'(emulate_command(OP_CLEAR, '0, '0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue_command(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].col,
                    directed_rows[i].row, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
      wait_for_drain();
      if (phase <= 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end else if (phase <= 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 1)      write_color(8'h00);
      else if (phase == 2) write_color(8'hFF);
      else                 write_color(ATTR_W'($urandom_range(255)));
      // Stall the result side while commands keep coming, to fill the skid path.
      if (phase == 7) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        pick_random_command(op, ch, col, row);
        issue_command(op, ch, col, row, 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d from the table), %0d results, %0d scrolls, %0d clears,",
             commands_sent, DIRECTED_COUNT, results_seen, scroll_count, clear_count);
    $display("%0d color writes and a %0d-cycle result stall in %0d cycles.",
             color_writes, HOLD_CYCLES, cycle_count);
    if (error_count == 0) begin
      $display("text_terminal_writer_test passed");
    end else begin
      $display("text_terminal_writer_test failed");
    end
    $finish;
  end

endmodule
